// File: rtl/fpfma_pkg.sv
// package: shared constants and types of the single-precision fused multiply-add unit
package fpfma_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W  = 12;
    localparam int unsigned NUM_STAGES = 9;

    localparam logic [WORD_W-1:0] QNAN_CANON    = 32'h7FC0_0000;
    localparam logic [WORD_W-1:0] ONE_BITS      = 32'h3F80_0000;
    localparam logic [WORD_W-1:0] NEG_ZERO_BITS = 32'h8000_0000;
    localparam logic [WORD_W-1:0] POS_INF_BITS  = 32'h7F80_0000;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_MADD  = 3'd3,
        FN_MSUB  = 3'd4,
        FN_NMSUB = 3'd5,
        FN_NMADD = 3'd6,
        FN_BAD   = 3'd7
    } func_t;

    typedef logic signed [EXP_W-1:0] exp_t;

endpackage

// File: rtl/fp32_fused_multiply_add_unit_core.sv
// top level: nine-stage pipelined single-precision fused multiply-add unit
// One operation enters per cycle while the output side does not stall, and the result comes
// from s9_res_reg; every stage holds its own valid bit, so a stall fills bubbles before it stops
// intake. Stages: operand decode and special cases, 24x24 multiply, product normalize, operand
// compare, alignment shift, add, leading-one search, rounding shift, round increment and pack.
// Rounding is nearest-even, subnormals are exact, and every NaN result is 0x7FC00000.
module fp32_fused_multiply_add_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] operand_c,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result
);

    localparam int unsigned NS = fpfma_pkg::NUM_STAGES;

    logic [NS:1]   vld_reg;
    logic [NS+1:1] en;

    always_comb
    begin
        en[NS+1] = out_ready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[NS];

    // stage 1: decode and special cases
    logic [31:0] x, y, z;
    logic        negp, negz, bad;
    logic        sp_n, sz_n, spc_n;
    logic [31:0] spc_res_n;
    logic        xnan, ynan, znan, xinf, yinf, zinf, xzero, yzero, zzero, pinf, pzero;

    always_comb
    begin
        x = operand_a;
        y = operand_b;
        z = operand_c;
        negp = 1'b0;
        negz = 1'b0;
        bad = 1'b0;
        unique case (fpfma_pkg::func_t'(func))
            fpfma_pkg::FN_ADD:
            begin
                y = fpfma_pkg::ONE_BITS;
                z = operand_b;
            end
            fpfma_pkg::FN_SUB:
            begin
                y = fpfma_pkg::ONE_BITS;
                z = operand_b;
                negz = 1'b1;
            end
            fpfma_pkg::FN_MUL:
            begin
                z = fpfma_pkg::NEG_ZERO_BITS;
            end
            fpfma_pkg::FN_MADD:
            begin
            end
            fpfma_pkg::FN_MSUB:
            begin
                negz = 1'b1;
            end
            fpfma_pkg::FN_NMSUB:
            begin
                negp = 1'b1;
            end
            fpfma_pkg::FN_NMADD:
            begin
                negp = 1'b1;
                negz = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        xnan  = (&x[30:23]) && (|x[22:0]);
        ynan  = (&y[30:23]) && (|y[22:0]);
        znan  = (&z[30:23]) && (|z[22:0]);
        xinf  = (&x[30:23]) && !(|x[22:0]);
        yinf  = (&y[30:23]) && !(|y[22:0]);
        zinf  = (&z[30:23]) && !(|z[22:0]);
        xzero = !(|x[30:0]);
        yzero = !(|y[30:0]);
        zzero = !(|z[30:0]);
        pinf  = xinf || yinf;
        pzero = xzero || yzero;
        sp_n  = x[31] ^ y[31] ^ negp;
        sz_n  = z[31] ^ negz;

        spc_n = 1'b1;
        spc_res_n = fpfma_pkg::QNAN_CANON;
        priority if (bad || xnan || ynan || znan)
        begin
            spc_res_n = fpfma_pkg::QNAN_CANON;
        end
        else if (pinf && pzero)
        begin
            spc_res_n = fpfma_pkg::QNAN_CANON;
        end
        else if (pinf && zinf && (sp_n != sz_n))
        begin
            spc_res_n = fpfma_pkg::QNAN_CANON;
        end
        else if (pinf)
        begin
            spc_res_n = {sp_n, fpfma_pkg::POS_INF_BITS[30:0]};
        end
        else if (zinf)
        begin
            spc_res_n = {sz_n, fpfma_pkg::POS_INF_BITS[30:0]};
        end
        else if (pzero && !zzero)
        begin
            spc_res_n = {sz_n, z[30:0]};
        end
        else if (pzero)
        begin
            spc_res_n = {(sp_n == sz_n) ? sp_n : 1'b0, 31'd0};
        end
        else
        begin
            spc_n = 1'b0;
        end
    end

    logic        s1_spc_reg, s1_sp_reg, s1_sz_reg;
    logic [31:0] s1_res_reg;
    logic [23:0] s1_mx_reg, s1_my_reg, s1_mz_reg;
    logic [9:0]  s1_ebase_reg;
    logic [7:0]  s1_ez_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_spc_reg   <= spc_n;
            s1_res_reg   <= spc_res_n;
            s1_sp_reg    <= sp_n;
            s1_sz_reg    <= sz_n;
            s1_mx_reg    <= {|x[30:23], x[22:0]};
            s1_my_reg    <= {|y[30:23], y[22:0]};
            s1_mz_reg    <= {|z[30:23], z[22:0]};
            s1_ebase_reg <= {2'b00, ((|x[30:23]) ? x[30:23] : 8'd1)}
                          + {2'b00, ((|y[30:23]) ? y[30:23] : 8'd1)};
            s1_ez_reg    <= (|z[30:23]) ? z[30:23] : 8'd1;
        end
    end

    // stage 2: multiply, normalize addend
    logic [4:0] pc;
    fpfma_msb #(.W(24)) u_msb_c (.v(s1_mz_reg), .pos(pc));

    logic        s2_spc_reg, s2_sp_reg, s2_sz_reg, s2_czero_reg;
    logic [31:0] s2_res_reg;
    logic [47:0] s2_prod_reg;
    logic [61:0] s2_mc_reg;
    logic [9:0]  s2_ebase_reg;
    fpfma_pkg::exp_t s2_ec_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_spc_reg   <= s1_spc_reg;
            s2_res_reg   <= s1_res_reg;
            s2_sp_reg    <= s1_sp_reg;
            s2_sz_reg    <= s1_sz_reg;
            s2_czero_reg <= !(|s1_mz_reg);
            s2_prod_reg  <= s1_mx_reg * s1_my_reg;
            s2_mc_reg    <= {s1_mz_reg, 38'd0} << (5'd23 - pc);
            s2_ebase_reg <= s1_ebase_reg;
            s2_ec_reg    <= fpfma_pkg::exp_t'({4'd0, s1_ez_reg}) - 12'sd211
                          + fpfma_pkg::exp_t'({7'd0, pc});
        end
    end

    // stage 3: normalize product
    logic [5:0] pp;
    fpfma_msb #(.W(48)) u_msb_p (.v(s2_prod_reg), .pos(pp));

    logic        s3_spc_reg, s3_sp_reg, s3_sz_reg, s3_czero_reg;
    logic [31:0] s3_res_reg;
    logic [61:0] s3_mp_reg, s3_mc_reg;
    fpfma_pkg::exp_t s3_ep_reg, s3_ec_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_spc_reg   <= s2_spc_reg;
            s3_res_reg   <= s2_res_reg;
            s3_sp_reg    <= s2_sp_reg;
            s3_sz_reg    <= s2_sz_reg;
            s3_czero_reg <= s2_czero_reg;
            s3_mp_reg    <= {s2_prod_reg, 14'd0} << (6'd47 - pp);
            s3_mc_reg    <= s2_mc_reg;
            s3_ep_reg    <= fpfma_pkg::exp_t'({2'd0, s2_ebase_reg}) - 12'sd361
                          + fpfma_pkg::exp_t'({6'd0, pp});
            s3_ec_reg    <= s2_ec_reg;
        end
    end

    // stage 4: compare and swap
    logic [61:0] hi_n, lo_n;
    fpfma_pkg::exp_t sl_n, diff_n;
    logic        sign_n, sub_n;
    logic [6:0]  d_n;

    always_comb
    begin
        if (s3_czero_reg)
        begin
            hi_n = s3_mp_reg;
            lo_n = '0;
            sl_n = s3_ep_reg;
            sign_n = s3_sp_reg;
            sub_n = 1'b0;
            diff_n = '0;
        end
        else if ((s3_ep_reg > s3_ec_reg)
              || ((s3_ep_reg == s3_ec_reg) && (s3_mp_reg >= s3_mc_reg)))
        begin
            hi_n = s3_mp_reg;
            lo_n = s3_mc_reg;
            sl_n = s3_ep_reg;
            sign_n = s3_sp_reg;
            sub_n = s3_sp_reg ^ s3_sz_reg;
            diff_n = s3_ep_reg - s3_ec_reg;
        end
        else
        begin
            hi_n = s3_mc_reg;
            lo_n = s3_mp_reg;
            sl_n = s3_ec_reg;
            sign_n = s3_sz_reg;
            sub_n = s3_sp_reg ^ s3_sz_reg;
            diff_n = s3_ec_reg - s3_ep_reg;
        end
        d_n = (diff_n > 12'sd63) ? 7'd64 : diff_n[6:0];
    end

    logic        s4_spc_reg, s4_sign_reg, s4_sub_reg;
    logic [31:0] s4_res_reg;
    logic [61:0] s4_hi_reg, s4_lo_reg;
    fpfma_pkg::exp_t s4_sl_reg;
    logic [6:0]  s4_d_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_spc_reg  <= s3_spc_reg;
            s4_res_reg  <= s3_res_reg;
            s4_sign_reg <= sign_n;
            s4_sub_reg  <= sub_n;
            s4_hi_reg   <= hi_n;
            s4_lo_reg   <= lo_n;
            s4_sl_reg   <= sl_n;
            s4_d_reg    <= d_n;
        end
    end

    // stage 5: align with sticky
    logic [63:0] lo64, amask, sv_n;

    always_comb
    begin
        lo64  = {2'b00, s4_lo_reg};
        amask = (64'd1 << s4_d_reg[5:0]) - 64'd1;
        if (s4_d_reg[6])
        begin
            sv_n = 64'd1;
        end
        else
        begin
            sv_n = (lo64 >> s4_d_reg[5:0]) | {63'd0, |(lo64 & amask)};
        end
    end

    logic        s5_spc_reg, s5_sign_reg, s5_sub_reg;
    logic [31:0] s5_res_reg;
    logic [63:0] s5_hi_reg, s5_sv_reg;
    fpfma_pkg::exp_t s5_sl_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_spc_reg  <= s4_spc_reg;
            s5_res_reg  <= s4_res_reg;
            s5_sign_reg <= s4_sign_reg;
            s5_sub_reg  <= s4_sub_reg;
            s5_hi_reg   <= {2'b00, s4_hi_reg};
            s5_sv_reg   <= sv_n;
            s5_sl_reg   <= s4_sl_reg;
        end
    end

    // stage 6: add or subtract
    logic [63:0] r_n;
    assign r_n = s5_sub_reg ? (s5_hi_reg - s5_sv_reg) : (s5_hi_reg + s5_sv_reg);

    logic        s6_spc_reg, s6_sign_reg;
    logic [31:0] s6_res_reg;
    logic [63:0] s6_r_reg;
    fpfma_pkg::exp_t s6_s_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_spc_reg  <= s5_spc_reg || (s5_sub_reg && !(|r_n));
            s6_res_reg  <= s5_spc_reg ? s5_res_reg : 32'd0;
            s6_sign_reg <= s5_sign_reg;
            s6_r_reg    <= r_n;
            s6_s_reg    <= s5_sl_reg;
        end
    end

    // stage 7: leading one and target exponent
    logic [5:0] pr;
    fpfma_pkg::exp_t t_raw, t_n;
    fpfma_msb #(.W(64)) u_msb_r (.v(s6_r_reg), .pos(pr));

    always_comb
    begin
        t_raw = fpfma_pkg::exp_t'({6'd0, pr}) + s6_s_reg - 12'sd23;
        t_n = (t_raw < -12'sd149) ? -12'sd149 : t_raw;
    end

    logic        s7_spc_reg, s7_sign_reg;
    logic [31:0] s7_res_reg;
    logic [63:0] s7_r_reg;
    fpfma_pkg::exp_t s7_t_reg, s7_sh_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_spc_reg  <= s6_spc_reg;
            s7_res_reg  <= s6_res_reg;
            s7_sign_reg <= s6_sign_reg;
            s7_r_reg    <= s6_r_reg;
            s7_t_reg    <= t_n;
            s7_sh_reg   <= t_n - s6_s_reg;
        end
    end

    // stage 8: rounding shift
    logic [23:0] m_n;
    logic        inc_n, guard;
    fpfma_pkg::exp_t nsh;
    logic [5:0]  shamt;
    logic [63:0] shifted, smask;

    always_comb
    begin
        m_n = '0;
        inc_n = 1'b0;
        nsh = -s7_sh_reg;
        shamt = s7_sh_reg[5:0];
        shifted = s7_r_reg >> shamt;
        smask = (64'd1 << (shamt - 6'd1)) - 64'd1;
        guard = s7_r_reg[shamt - 6'd1];
        if (s7_sh_reg <= 12'sd0)
        begin
            m_n = s7_r_reg[23:0] << nsh[4:0];
        end
        else if (s7_sh_reg <= 12'sd63)
        begin
            m_n = shifted[23:0];
            inc_n = guard && ((|(s7_r_reg & smask)) || shifted[0]);
        end
    end

    logic        s8_spc_reg, s8_sign_reg, s8_inc_reg;
    logic [31:0] s8_res_reg;
    logic [23:0] s8_m_reg;
    fpfma_pkg::exp_t s8_t_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_spc_reg  <= s7_spc_reg;
            s8_res_reg  <= s7_res_reg;
            s8_sign_reg <= s7_sign_reg;
            s8_inc_reg  <= inc_n;
            s8_m_reg    <= m_n;
            s8_t_reg    <= s7_t_reg;
        end
    end

    // stage 9: increment and pack
    logic [24:0] mm, mf;
    fpfma_pkg::exp_t tf, be;
    logic [31:0] packed_n;

    always_comb
    begin
        mm = {1'b0, s8_m_reg} + {24'd0, s8_inc_reg};
        mf = mm;
        tf = s8_t_reg;
        if (mm[24])
        begin
            mf = mm >> 1;
            tf = s8_t_reg + 12'sd1;
        end
        be = tf + 12'sd150;
        if (s8_spc_reg)
        begin
            packed_n = s8_res_reg;
        end
        else if (mf[23])
        begin
            if (be >= 12'sd255)
            begin
                packed_n = {s8_sign_reg, fpfma_pkg::POS_INF_BITS[30:0]};
            end
            else
            begin
                packed_n = {s8_sign_reg, be[7:0], mf[22:0]};
            end
        end
        else
        begin
            packed_n = {s8_sign_reg, 8'd0, mf[22:0]};
        end
    end

    logic [31:0] s9_res_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_res_reg <= packed_n;
        end
    end

    assign result = s9_res_reg;

endmodule

// File: rtl/fpfma_msb.sv
// leading-one position finder
module fpfma_msb #(
    parameter int unsigned W = 64
) (
    input  logic [W-1:0]         v,
    output logic [$clog2(W)-1:0] pos
);

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < W; i++)
        begin
            if (v[i])
            begin
                pos = ($clog2(W))'(i);
            end
        end
    end

endmodule

// File: test/fp32_fused_multiply_add_unit_core_test.sv
// testbench: fused multiply-add unit checked against a bit-exact single-rounding predictor
`timescale 1ns / 1ps

module fp32_fused_multiply_add_unit_core_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result;

    int error_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    fp32_fused_multiply_add_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    function automatic logic is_nan_bits(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic logic is_inf_bits(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 0;
    endfunction

    function automatic logic is_zero_bits(logic [31:0] v);
        return v[30:0] == 0;
    endfunction

    function automatic logic [23:0] significand(logic [31:0] v);
        return (v[30:23] != 0) ? {1'b1, v[22:0]} : {1'b0, v[22:0]};
    endfunction

    function automatic int biased_exp(logic [31:0] v);
        return (v[30:23] != 0) ? int'(v[30:23]) : 1;
    endfunction

    // rounds sign * mag * 2^scale to nearest even
    function automatic logic [31:0] round_to_single(logic sgn, logic [63:0] mag, int scale);
        int          msb;
        int          target;
        int          shift;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        msb = 63;
        while (msb > 0 && !mag[msb])
            msb--;
        target = msb + scale - 23;
        if (target < -149)
            target = -149;
        shift = target - scale;
        if (shift <= 0)
            m = mag << (-shift);
        else if (shift > 63)
            m = 0;
        else
        begin
            rem  = mag & ((64'd1 << shift) - 1);
            half = 64'd1 << (shift - 1);
            m    = mag >> shift;
            if (rem > half || (rem == half && m[0]))
                m++;
        end
        if (m >= (64'd1 << 24))
        begin
            m = m >> 1;
            target++;
        end
        if (m >= (64'd1 << 23))
        begin
            if (target + 150 >= 255)
                return {sgn, 31'h7F80_0000};
            return {sgn, 8'(target + 150), m[22:0]};
        end
        return {sgn, m[30:0]};
    endfunction

    function automatic logic [31:0] fused_mul_add(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic neg_prod,
                                                  logic neg_add);
        logic        prod_sign;
        logic        add_sign;
        logic        prod_inf;
        logic        prod_zero;
        logic [63:0] prod_mag;
        logic [63:0] add_mag;
        logic [63:0] big;
        logic [63:0] tiny;
        logic [63:0] aligned;
        logic [63:0] total;
        int          prod_exp;
        int          add_exp;
        int          big_exp;
        int          gap;
        logic        big_sign;
        logic        tiny_sign;
        prod_sign = x[31] ^ y[31] ^ neg_prod;
        add_sign  = z[31] ^ neg_add;
        if (is_nan_bits(x) || is_nan_bits(y) || is_nan_bits(z))
            return fpfma_pkg::QNAN_CANON;
        prod_inf  = is_inf_bits(x) || is_inf_bits(y);
        prod_zero = is_zero_bits(x) || is_zero_bits(y);
        if (prod_inf && prod_zero)
            return fpfma_pkg::QNAN_CANON;
        if (prod_inf && is_inf_bits(z) && prod_sign != add_sign)
            return fpfma_pkg::QNAN_CANON;
        if (prod_inf)
            return {prod_sign, 31'h7F80_0000};
        if (is_inf_bits(z))
            return {add_sign, 31'h7F80_0000};
        if (prod_zero)
        begin
            if (!is_zero_bits(z))
                return {add_sign, z[30:0]};
            return (prod_sign == add_sign) ? {prod_sign, 31'd0} : 32'd0;
        end
        prod_mag = 64'(significand(x)) * 64'(significand(y));
        prod_exp = biased_exp(x) + biased_exp(y) - 300;
        while (!prod_mag[61])
        begin
            prod_mag = prod_mag << 1;
            prod_exp--;
        end
        add_mag = 64'(significand(z));
        if (add_mag == 0)
            return round_to_single(prod_sign, prod_mag, prod_exp);
        add_exp = biased_exp(z) - 150;
        while (!add_mag[61])
        begin
            add_mag = add_mag << 1;
            add_exp--;
        end
        if (prod_exp > add_exp || (prod_exp == add_exp && prod_mag >= add_mag))
        begin
            big = prod_mag; big_exp = prod_exp; big_sign = prod_sign;
            tiny = add_mag; gap = prod_exp - add_exp; tiny_sign = add_sign;
        end
        else
        begin
            big = add_mag; big_exp = add_exp; big_sign = add_sign;
            tiny = prod_mag; gap = add_exp - prod_exp; tiny_sign = prod_sign;
        end
        if (gap == 0)
            aligned = tiny;
        else if (gap >= 64)
            aligned = 1;
        else
            aligned = (tiny >> gap) | 64'((tiny & ((64'd1 << gap) - 1)) != 0);
        if (big_sign == tiny_sign)
            total = big + aligned;
        else
        begin
            total = big - aligned;
            if (total == 0)
                return 32'd0;
        end
        return round_to_single(big_sign, total, big_exp);
    endfunction

    function automatic logic [31:0] predict_result(fpfma_pkg::func_t fn, logic [31:0] a,
                                                   logic [31:0] b, logic [31:0] c);
        case (fn)
            fpfma_pkg::FN_ADD:
                return fused_mul_add(a, fpfma_pkg::ONE_BITS, b, 1'b0, 1'b0);
            fpfma_pkg::FN_SUB:
                return fused_mul_add(a, fpfma_pkg::ONE_BITS, b, 1'b0, 1'b1);
            fpfma_pkg::FN_MUL:
                return fused_mul_add(a, b, fpfma_pkg::NEG_ZERO_BITS, 1'b0, 1'b0);
            fpfma_pkg::FN_MADD:  return fused_mul_add(a, b, c, 1'b0, 1'b0);
            fpfma_pkg::FN_MSUB:  return fused_mul_add(a, b, c, 1'b0, 1'b1);
            fpfma_pkg::FN_NMSUB: return fused_mul_add(a, b, c, 1'b1, 1'b0);
            fpfma_pkg::FN_NMADD: return fused_mul_add(a, b, c, 1'b1, 1'b1);
            default:             return fpfma_pkg::QNAN_CANON;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    class fma_scoreboard;
        logic [31:0] pending_results[$];

        function void note_operation(fpfma_pkg::func_t fn, logic [31:0] a, logic [31:0] b,
                                     logic [31:0] c);
            pending_results.push_back(predict_result(fn, a, b, c));
        endfunction

        task check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result %h, expected %h", got, want));
        endtask
    endclass

    fma_scoreboard board;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_operation(fpfma_pkg::func_t'(func), operand_a, operand_b,
                                     operand_c);
            if (out_valid && out_ready)
                board.check_result(result);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0] = 31'd0;
            3: v[30:23] = 8'($urandom_range(120, 135));
            4: v[30:23] = 8'($urandom_range(240, 254));
            5: v[30:23] = 8'($urandom_range(1, 12));
            default: v[30:23] = 8'($urandom_range(100, 155));
        endcase
        return v;
    endfunction

    task automatic send_operation(fpfma_pkg::func_t fn, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= fn;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [31:0] a;
        logic [31:0] c;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            c = random_operand();
            // addend c made close to the negation of operand a
            if ($urandom_range(5) == 0)
                c = {~a[31], a[30:0] ^ 31'($urandom_range(3))};
            send_operation(fpfma_pkg::func_t'($urandom_range(7)), a, random_operand(), c);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board          = new();
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = fpfma_pkg::FN_ADD;
        operand_a      = 32'd0;
        operand_b      = 32'd0;
        operand_c      = 32'd0;
        out_ready      = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_operation(fpfma_pkg::FN_ADD,   32'h3F80_0000, 32'h4000_0000, 32'd0);
        send_operation(fpfma_pkg::FN_SUB,   32'h3F80_0000, 32'h3F80_0000, 32'd0);
        send_operation(fpfma_pkg::FN_MUL,   32'h7F7F_FFFF, 32'h4000_0000, 32'd0);
        send_operation(fpfma_pkg::FN_MUL,   32'h0000_0001, 32'h3F00_0000, 32'd0);
        send_operation(fpfma_pkg::FN_MUL,   32'h8000_0000, 32'h3F80_0000, 32'd0);
        send_operation(fpfma_pkg::FN_MADD,  32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000);
        send_operation(fpfma_pkg::FN_MADD,  32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000);
        send_operation(fpfma_pkg::FN_MSUB,  32'h7FC0_1234, 32'h3F80_0000, 32'h3F80_0000);
        send_operation(fpfma_pkg::FN_NMSUB, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        send_operation(fpfma_pkg::FN_NMADD, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_operation(fpfma_pkg::FN_MADD,  32'h8000_0000, 32'h3F80_0000, 32'h8000_0000);
        send_operation(fpfma_pkg::FN_BAD,   32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        send_operation(fpfma_pkg::FN_ADD,   32'h0080_0000, 32'h8000_0001, 32'd0);
        send_operation(fpfma_pkg::FN_MADD,  32'h3F80_0001, 32'h3F7F_FFFF, 32'hBF80_0000);
        send_operation(fpfma_pkg::FN_NMADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operation(fpfma_pkg::FN_SUB,   32'h7F80_0000, 32'h7F80_0000, 32'd0);
        send_operation(fpfma_pkg::FN_MADD,  32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000);
        wait_drained();

        send_random(500);
        send_idle_pct = 51;
        send_random(480);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        send_random(480);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        send_random(480);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && board.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: files.f
rtl/fpfma_pkg.sv
rtl/fpfma_msb.sv
rtl/fp32_fused_multiply_add_unit_core.sv
test/fp32_fused_multiply_add_unit_core_test.sv
